// ----- rtl/core/fermion_occupation_operator_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Fermion occupation operator unit: assertion macros
// Shared clocked assertion forms, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef FERMION_OCCUPATION_OPERATOR_UNIT_DEFINES_SVH
`define FERMION_OCCUPATION_OPERATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Property holds at every rising edge outside reset.
`define FOOE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen at a rising edge outside reset.
`define FOOE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FOOE_ASSERT(label, clk, rst_n, prop, msg)
`define FOOE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/core/fooe_pkg.sv -----
// ---------------------------------------------------------------------------
// Fermion occupation operator unit: package
// Transfer types, operation and phase codes, and the parity helper.
// ---------------------------------------------------------------------------
package fooe_pkg;

    localparam int STRING_W = 64;
    localparam int INDEX_W  = 6;
    localparam int OP_W     = 4;
    localparam int COUNT_W  = 7;
    localparam int SPIN_W   = 8;

    localparam logic [OP_W-1:0] OP_LOAD      = 4'd0;
    localparam logic [OP_W-1:0] OP_CREATE_A  = 4'd1;
    localparam logic [OP_W-1:0] OP_CREATE_B  = 4'd2;
    localparam logic [OP_W-1:0] OP_DESTROY_A = 4'd3;
    localparam logic [OP_W-1:0] OP_DESTROY_B = 4'd4;
    localparam logic [OP_W-1:0] OP_DOUBLE_AA = 4'd5;
    localparam logic [OP_W-1:0] OP_DOUBLE_AB = 4'd6;
    localparam logic [OP_W-1:0] OP_DOUBLE_BB = 4'd7;
    localparam logic [OP_W-1:0] OP_FLIP      = 4'd8;
    localparam logic [OP_W-1:0] OP_SIGN_A    = 4'd9;
    localparam logic [OP_W-1:0] OP_SIGN_B    = 4'd10;

    typedef logic signed [1:0] t_phase;

    localparam t_phase PHASE_ZERO = 2'sb00;
    localparam t_phase PHASE_POS  = 2'sb01;
    localparam t_phase PHASE_NEG  = 2'sb11;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [INDEX_W-1:0]  index_i;
        logic [INDEX_W-1:0]  index_j;
        logic [INDEX_W-1:0]  index_a;
        logic [INDEX_W-1:0]  index_b;
        logic [STRING_W-1:0] load_alpha;
        logic [STRING_W-1:0] load_beta;
    } t_fooe_in;

    typedef struct packed {
        t_phase                    phase;
        logic [STRING_W-1:0]       alpha_string;
        logic [STRING_W-1:0]       beta_string;
        logic signed [SPIN_W-1:0]  twice_spin_z;
    } t_fooe_out;

    // Outcome of one operation before the spin count is added.
    typedef struct packed {
        t_phase              phase;
        logic [STRING_W-1:0] alpha;
        logic [STRING_W-1:0] beta;
    } t_fooe_step;

    // True when an odd number of bits of s lie below position n.
    function automatic logic odd_below(input logic [STRING_W-1:0] s,
                                       input logic [INDEX_W-1:0]  n);
        logic [STRING_W-1:0] below;
        below = (STRING_W'(1) << n) - STRING_W'(1);
        return ^(s & below);
    endfunction

    function automatic t_phase phase_of(input logic odd);
        return odd ? PHASE_NEG : PHASE_POS;
    endfunction

endpackage

// ----- rtl/core/fooe_exec.sv -----
// ---------------------------------------------------------------------------
// Fermion occupation operator unit: operation logic
// Applies one operation to the held strings and works out its phase.
// ---------------------------------------------------------------------------
module fooe_exec #(
    parameter int NMO = 64
) (
    input  fooe_pkg::t_fooe_in              i_item,
    input  logic [fooe_pkg::STRING_W-1:0]   i_alpha,
    input  logic [fooe_pkg::STRING_W-1:0]   i_beta,
    output fooe_pkg::t_fooe_step            o_step
);
    import fooe_pkg::*;

    localparam logic [STRING_W-1:0] ORB_MASK = {STRING_W{1'b1}} >> (STRING_W - NMO);

    logic [STRING_W-1:0] bit_i, bit_j, bit_a, bit_b;
    logic [STRING_W-1:0] aa_alpha, bb_beta, ab_alpha, ab_beta;
    logic                odd_ai, odd_aj, odd_bi, odd_bj;
    logic                odd_aa, odd_ab, odd_bb;

    assign bit_i = (STRING_W'(1) << i_item.index_i) & ORB_MASK;
    assign bit_j = (STRING_W'(1) << i_item.index_j) & ORB_MASK;
    assign bit_a = (STRING_W'(1) << i_item.index_a) & ORB_MASK;
    assign bit_b = (STRING_W'(1) << i_item.index_b) & ORB_MASK;

    assign odd_ai = odd_below(i_alpha, i_item.index_i);
    assign odd_aj = odd_below(i_alpha, i_item.index_j);
    assign odd_bi = odd_below(i_beta, i_item.index_i);
    assign odd_bj = odd_below(i_beta, i_item.index_j);

    // The removed orbitals are cleared before the added ones are set.
    assign aa_alpha = (i_alpha & ~(bit_i | bit_j)) | bit_a | bit_b;
    assign bb_beta  = (i_beta & ~(bit_i | bit_j)) | bit_a | bit_b;
    assign ab_alpha = (i_alpha & ~bit_i) | bit_a;
    assign ab_beta  = (i_beta & ~bit_j) | bit_b;

    assign odd_aa = odd_ai ^ odd_aj ^ odd_below(aa_alpha, i_item.index_a)
                    ^ odd_below(aa_alpha, i_item.index_b);
    assign odd_bb = odd_bi ^ odd_bj ^ odd_below(bb_beta, i_item.index_a)
                    ^ odd_below(bb_beta, i_item.index_b);
    assign odd_ab = odd_ai ^ odd_bj ^ odd_below(ab_alpha, i_item.index_a)
                    ^ odd_below(ab_beta, i_item.index_b);

    always_comb begin
        o_step.phase = PHASE_ZERO;
        o_step.alpha = i_alpha;
        o_step.beta  = i_beta;
        unique case (i_item.operation)
            OP_LOAD: begin
                o_step.alpha = i_item.load_alpha & ORB_MASK;
                o_step.beta  = i_item.load_beta & ORB_MASK;
                o_step.phase = PHASE_POS;
            end
            OP_CREATE_A: begin
                if ((bit_i != '0) && ((i_alpha & bit_i) == '0)) begin
                    o_step.alpha = i_alpha | bit_i;
                    o_step.phase = phase_of(odd_ai);
                end
            end
            OP_CREATE_B: begin
                if ((bit_i != '0) && ((i_beta & bit_i) == '0)) begin
                    o_step.beta  = i_beta | bit_i;
                    o_step.phase = phase_of(odd_bi);
                end
            end
            OP_DESTROY_A: begin
                if ((i_alpha & bit_i) != '0) begin
                    o_step.alpha = i_alpha & ~bit_i;
                    o_step.phase = phase_of(odd_ai);
                end
            end
            OP_DESTROY_B: begin
                if ((i_beta & bit_i) != '0) begin
                    o_step.beta  = i_beta & ~bit_i;
                    o_step.phase = phase_of(odd_bi);
                end
            end
            OP_DOUBLE_AA: begin
                o_step.alpha = aa_alpha;
                o_step.phase = phase_of(odd_aa);
            end
            OP_DOUBLE_AB: begin
                o_step.alpha = ab_alpha;
                o_step.beta  = ab_beta;
                o_step.phase = phase_of(odd_ab);
            end
            OP_DOUBLE_BB: begin
                o_step.beta  = bb_beta;
                o_step.phase = phase_of(odd_bb);
            end
            OP_FLIP: begin
                o_step.alpha = i_beta;
                o_step.beta  = i_alpha;
                o_step.phase = PHASE_POS;
            end
            OP_SIGN_A: begin
                o_step.phase = phase_of(odd_ai);
            end
            OP_SIGN_B: begin
                o_step.phase = phase_of(odd_bi);
            end
            default: begin
                o_step.phase = PHASE_ZERO;
            end
        endcase
    end

endmodule

// ----- rtl/core/fooe_spin.sv -----
// ---------------------------------------------------------------------------
// Fermion occupation operator unit: spin count
// Twice Sz as the alpha population minus the beta population.
// ---------------------------------------------------------------------------
module fooe_spin (
    input  logic [fooe_pkg::STRING_W-1:0]       i_alpha,
    input  logic [fooe_pkg::STRING_W-1:0]       i_beta,
    output logic signed [fooe_pkg::SPIN_W-1:0]  o_twice_spin_z
);
    import fooe_pkg::*;

    logic [COUNT_W-1:0] count_alpha, count_beta;

    assign count_alpha = COUNT_W'($countones(i_alpha));
    assign count_beta  = COUNT_W'($countones(i_beta));

    assign o_twice_spin_z = $signed({1'b0, count_alpha}) - $signed({1'b0, count_beta});

endmodule

// ----- rtl/core/fermion_occupation_operator_unit.sv -----
// ---------------------------------------------------------------------------
// Fermion occupation operator unit
// Holds one determinant as alpha and beta occupation strings and applies
// creation, annihilation, double excitation, flip and sign operations.
// ---------------------------------------------------------------------------
//
//  Channel   Valid          Stall          Payload
//  -------   ------------   ------------   ------------------------
//  input     i_in_valid     o_in_stall     i_in_item  (t_fooe_in)
//  result    o_out_valid    i_out_stall    o_out_item (t_fooe_out)
//
// Every transfer in gives exactly one transfer out. The unit sustains one
// operation per cycle while the result side does not stall; an operation
// passes through the input register and then the result register, from
// which its result leaves. The occupation strings are updated in the same
// edge as the result register. Reset clears both strings and both valid
// flags. A stall on the result side holds the result register, and the
// input register then holds too, so o_in_stall rises only once both
// registers are occupied.
//
module fermion_occupation_operator_unit #(
    parameter int NMO = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fooe_pkg::t_fooe_in   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fooe_pkg::t_fooe_out  o_out_item
);
    import fooe_pkg::*;

`include "fermion_occupation_operator_unit_defines.svh"

    localparam logic [STRING_W-1:0] ORB_MASK = {STRING_W{1'b1}} >> (STRING_W - NMO);

    // Input register: holds the operation waiting to be applied.
    logic      r_in_valid, n_in_valid;
    t_fooe_in  r_in;

    // Determinant state, always equal to the strings of the last result.
    logic [STRING_W-1:0] r_alpha, r_beta;

    // Result register.
    logic       r_out_valid, n_out_valid;
    t_fooe_out  r_out;

    t_fooe_step              step;
    logic signed [SPIN_W-1:0] spin;
    logic                    in_take;
    logic                    exec_fire;

    fooe_exec #(
        .NMO (NMO)
    ) u_exec (
        .i_item  (r_in),
        .i_alpha (r_alpha),
        .i_beta  (r_beta),
        .o_step  (step)
    );

    fooe_spin u_spin (
        .i_alpha        (step.alpha),
        .i_beta         (step.beta),
        .o_twice_spin_z (spin)
    );

    // The held operation is applied when the result register is free or is
    // being emptied in this same cycle.
    assign exec_fire  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec_fire;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (exec_fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (exec_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_alpha     <= '0;
            r_beta      <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (exec_fire) begin
                r_alpha <= step.alpha;
                r_beta  <= step.beta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (exec_fire) begin
            r_out.phase        <= step.phase;
            r_out.alpha_string <= step.alpha;
            r_out.beta_string  <= step.beta;
            r_out.twice_spin_z <= spin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The strings never carry orbitals at or above NMO.
    `FOOE_ASSERT_NEVER(a_orbital_range, i_clk, i_rst_n, ((r_alpha | r_beta) & ~ORB_MASK) != '0, "string holds an orbital beyond NMO")

    // A pending result always shows the strings the unit now holds.
    `FOOE_ASSERT(a_result_matches_state, i_clk, i_rst_n, r_out_valid |-> (r_out.alpha_string == r_alpha && r_out.beta_string == r_beta), "result strings differ from held state")

    // The phase is one of +1, -1 and 0.
    `FOOE_ASSERT_NEVER(a_phase_code, i_clk, i_rst_n, r_out_valid && r_out.phase == 2'sb10, "phase code out of range")

    // An applied operation always leaves a result behind.
    `FOOE_ASSERT(a_fire_gives_result, i_clk, i_rst_n, exec_fire |=> r_out_valid, "applied operation lost its result")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fermion occupation operator unit: testbench
// Drives loads, single creations and annihilations, double excitations,
// spin flips and sign queries through the valid/stall input channel. A
// behavioural copy of the determinant predicts each result, and the result
// channel is checked field by field, in order, under random idling.
// ---------------------------------------------------------------------------
module tb;

    import fooe_pkg::*;

    localparam int NMO           = 64;
    localparam int RANDOM_OPS    = 1950;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [STRING_W-1:0] ORB_MASK = {STRING_W{1'b1}} >> (STRING_W - NMO);
    localparam logic [STRING_W-1:0] ALL_ONES = {STRING_W{1'b1}};

    // One queued operation. When drain is set, the driver holds it back
    // until every result already owed by the unit has come out.
    typedef struct packed {
        logic     drain;
        t_fooe_in item;
    } t_job;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_fooe_in  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_fooe_out o_out_item;

    // Predicted determinant: updated once per accepted input transfer.
    logic [STRING_W-1:0] alpha_occ = '0;
    logic [STRING_W-1:0] beta_occ  = '0;

    t_job      pending_ops[$];
    t_fooe_out expected_results[$];
    t_job      next_job;
    t_fooe_out wanted;

    int total_ops     = 1;
    int ops_sent      = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    fermion_occupation_operator_unit #(
        .NMO(NMO)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    // Single-orbital mask; an orbital at or beyond NMO has none.
    function automatic logic [STRING_W-1:0] orbital_mask(input logic [INDEX_W-1:0] n);
        return (int'(n) < NMO) ? (STRING_W'(1) << n) : '0;
    endfunction

    // Parity of the occupied orbitals strictly below orbital n.
    function automatic logic parity_below(input logic [STRING_W-1:0] s,
                                          input logic [INDEX_W-1:0]  n);
        logic p;
        p = 1'b0;
        for (int k = 0; k < STRING_W; k++) begin
            if (k < int'(n)) begin
                p ^= s[k];
            end
        end
        return p;
    endfunction

    function automatic t_phase fermion_sign(input logic [STRING_W-1:0] s,
                                            input logic [INDEX_W-1:0]  n);
        return parity_below(s, n) ? PHASE_NEG : PHASE_POS;
    endfunction

    // Applies one operation to the predicted determinant and returns the
    // result that the unit should deliver for it.
    function automatic t_fooe_out apply_operation(input t_fooe_in op);
        t_fooe_out           res;
        t_phase              ph;
        logic                odd;
        logic                make;
        logic                on_beta;
        logic [STRING_W-1:0] s;
        logic [STRING_W-1:0] m;
        ph  = PHASE_ZERO;
        odd = 1'b0;
        case (op.operation)
            OP_LOAD: begin
                alpha_occ = op.load_alpha & ORB_MASK;
                beta_occ  = op.load_beta & ORB_MASK;
                ph        = PHASE_POS;
            end
            OP_CREATE_A, OP_CREATE_B, OP_DESTROY_A, OP_DESTROY_B: begin
                make    = (op.operation == OP_CREATE_A) || (op.operation == OP_CREATE_B);
                on_beta = (op.operation == OP_CREATE_B) || (op.operation == OP_DESTROY_B);
                s       = on_beta ? beta_occ : alpha_occ;
                m       = orbital_mask(op.index_i);
                // Refused when the orbital is already in the wanted state.
                if (m != '0 && ((s & m) != '0) != make) begin
                    s  = s ^ m;
                    ph = fermion_sign(s, op.index_i);
                end
                if (on_beta) begin
                    beta_occ = s;
                end else begin
                    alpha_occ = s;
                end
            end
            OP_DOUBLE_AA: begin
                odd = parity_below(alpha_occ, op.index_i) ^ parity_below(alpha_occ, op.index_j);
                alpha_occ &= ~(orbital_mask(op.index_i) | orbital_mask(op.index_j));
                alpha_occ |= orbital_mask(op.index_a) | orbital_mask(op.index_b);
                odd ^= parity_below(alpha_occ, op.index_a) ^ parity_below(alpha_occ, op.index_b);
                ph = odd ? PHASE_NEG : PHASE_POS;
            end
            OP_DOUBLE_AB: begin
                odd = parity_below(alpha_occ, op.index_i) ^ parity_below(beta_occ, op.index_j);
                alpha_occ &= ~orbital_mask(op.index_i);
                beta_occ  &= ~orbital_mask(op.index_j);
                alpha_occ |= orbital_mask(op.index_a);
                beta_occ  |= orbital_mask(op.index_b);
                odd ^= parity_below(alpha_occ, op.index_a) ^ parity_below(beta_occ, op.index_b);
                ph = odd ? PHASE_NEG : PHASE_POS;
            end
            OP_DOUBLE_BB: begin
                odd = parity_below(beta_occ, op.index_i) ^ parity_below(beta_occ, op.index_j);
                beta_occ &= ~(orbital_mask(op.index_i) | orbital_mask(op.index_j));
                beta_occ |= orbital_mask(op.index_a) | orbital_mask(op.index_b);
                odd ^= parity_below(beta_occ, op.index_a) ^ parity_below(beta_occ, op.index_b);
                ph = odd ? PHASE_NEG : PHASE_POS;
            end
            OP_FLIP: begin
                s         = alpha_occ;
                alpha_occ = beta_occ;
                beta_occ  = s;
                ph        = PHASE_POS;
            end
            OP_SIGN_A: ph = fermion_sign(alpha_occ, op.index_i);
            OP_SIGN_B: ph = fermion_sign(beta_occ, op.index_i);
            default:   ph = PHASE_ZERO;
        endcase
        res.phase        = ph;
        res.alpha_string = alpha_occ;
        res.beta_string  = beta_occ;
        res.twice_spin_z = SPIN_W'($countones(alpha_occ) - $countones(beta_occ));
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------

    function automatic t_job make_job(input logic [OP_W-1:0]     op,
                                      input logic [INDEX_W-1:0]  i,
                                      input logic [INDEX_W-1:0]  j,
                                      input logic [INDEX_W-1:0]  a,
                                      input logic [INDEX_W-1:0]  b,
                                      input logic [STRING_W-1:0] la,
                                      input logic [STRING_W-1:0] lb);
        t_job job;
        job.drain           = 1'b0;
        job.item.operation  = op;
        job.item.index_i    = i;
        job.item.index_j    = j;
        job.item.index_a    = a;
        job.item.index_b    = b;
        job.item.load_alpha = la;
        job.item.load_beta  = lb;
        return job;
    endfunction

    // Every field is random, including those the operation ignores. Loads
    // sometimes carry sparse or dense strings so that creations and
    // annihilations are refused at differing rates.
    function automatic t_job random_job();
        t_job job;
        job.drain           = 1'b0;
        job.item.index_i    = INDEX_W'($urandom);
        job.item.index_j    = INDEX_W'($urandom);
        job.item.index_a    = INDEX_W'($urandom);
        job.item.index_b    = INDEX_W'($urandom);
        job.item.load_alpha = {$urandom, $urandom};
        job.item.load_beta  = {$urandom, $urandom};
        case ($urandom_range(3, 0))
            0: job.item.load_alpha &= {$urandom, $urandom};
            1: job.item.load_beta  |= {$urandom, $urandom};
            default: ;
        endcase
        if ($urandom_range(99, 0) < 4) begin
            job.item.operation = OP_W'($urandom_range(15, 11));
        end else begin
            job.item.operation = OP_W'($urandom_range(10, 0));
        end
        return job;
    endfunction

    // Appends an operation to the tail of the pending list.
    task automatic queue_job(input t_job job);
        pending_ops = {pending_ops, job};
    endtask

    // Appends a prediction to the tail of the expected results.
    task automatic queue_result(input t_fooe_out res);
        expected_results = {expected_results, res};
    endtask

    // Idle percentages: a busy sender with a slow receiver first, then the
    // reverse, then both sides at full rate.
    function automatic int idle_pct(input int count, input bit receiver);
        int third;
        third = (count * 3) / total_ops;
        if (third == 0) begin
            return receiver ? 72 : 15;
        end else if (third == 1) begin
            return receiver ? 15 : 72;
        end
        return 0;
    endfunction

    // -----------------------------------------------------------------------
    // Driver: records each accepted transfer with the predictor and offers
    // the next pending operation unless it chooses to idle.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                queue_result(apply_operation(i_in_item));
                ops_sent++;
            end
            if (i_in_valid && o_in_stall) begin
                // A stalled transfer keeps its payload and its valid.
            end else if (pending_ops.size() != 0
                         && !(pending_ops[0].drain && expected_results.size() != 0)
                         && $urandom_range(99, 0) >= idle_pct(ops_sent, 1'b0)) begin
                next_job = pending_ops.pop_front();
                i_in_item  <= next_job.item;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: compares each accepted result with the oldest prediction and
    // draws a fresh stall decision every cycle.
    // -----------------------------------------------------------------------
    task automatic report_field(input string field, input int unsigned idx,
                                input logic [STRING_W-1:0] want,
                                input logic [STRING_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("Mismatch in %s of result %0d: expected %h, got %h",
                     field, idx, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("Unexpected result %0d: nothing was predicted", results_seen);
                    end
                end else begin
                    wanted = expected_results.pop_front();
                    if (o_out_item.phase !== wanted.phase) begin
                        report_field("phase", results_seen, STRING_W'(wanted.phase),
                                     STRING_W'(o_out_item.phase));
                    end
                    if (o_out_item.alpha_string !== wanted.alpha_string) begin
                        report_field("alpha_string", results_seen, wanted.alpha_string,
                                     o_out_item.alpha_string);
                    end
                    if (o_out_item.beta_string !== wanted.beta_string) begin
                        report_field("beta_string", results_seen, wanted.beta_string,
                                     o_out_item.beta_string);
                    end
                    if (o_out_item.twice_spin_z !== wanted.twice_spin_z) begin
                        report_field("twice_spin_z", results_seen,
                                     STRING_W'(wanted.twice_spin_z),
                                     STRING_W'(o_out_item.twice_spin_z));
                    end
                end
                results_seen++;
            end
            i_out_stall <= ($urandom_range(99, 0) < idle_pct(results_seen, 1'b1));
        end
    end

    // Watchdog: ends the run when neither channel has moved a transfer for
    // far longer than the slowest correct run would ever need.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequence: directed cases, then the random run, then the final verdict.
    // -----------------------------------------------------------------------
    initial begin
        t_job job;

        // From the empty determinant: a query, a refused annihilation, creations at both
        // ends of the string with a refused repeat, then a beta annihilation and its refused repeat.
        queue_job(make_job(OP_SIGN_A,    6'd0,  6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_DESTROY_A, 6'd0,  6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_CREATE_A,  6'd0,  6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_CREATE_A,  6'd0,  6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_CREATE_A,  6'd63, 6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_CREATE_B,  6'd63, 6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_CREATE_B,  6'd0,  6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_DESTROY_B, 6'd63, 6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_DESTROY_B, 6'd63, 6'd0,  6'd0,  6'd0,  '0, '0));
        // Fully occupied strings: odd parity below the top orbital.
        queue_job(make_job(OP_LOAD,      6'd0,  6'd0,  6'd0,  6'd0,
                           ALL_ONES, ALL_ONES));
        queue_job(make_job(OP_SIGN_A,    6'd63, 6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_SIGN_B,    6'd0,  6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_CREATE_B,  6'd17, 6'd0,  6'd0,  6'd0,  '0, '0));
        // Double excitations with coinciding and extreme indices.
        queue_job(make_job(OP_DOUBLE_AA, 6'd0,  6'd63, 6'd0,  6'd63, '0, '0));
        queue_job(make_job(OP_DOUBLE_AB, 6'd5,  6'd5,  6'd7,  6'd7,  '0, '0));
        queue_job(make_job(OP_DOUBLE_BB, 6'd63, 6'd63, 6'd63, 6'd63, '0, '0));
        queue_job(make_job(OP_DOUBLE_AA, 6'd3,  6'd40, 6'd2,  6'd2,  '0, '0));
        // Largest positive and negative spin, reached through a flip.
        queue_job(make_job(OP_LOAD,      6'd0,  6'd0,  6'd0,  6'd0,  ALL_ONES, '0));
        queue_job(make_job(OP_FLIP,      6'd0,  6'd0,  6'd0,  6'd0,  '0, '0));
        queue_job(make_job(OP_DESTROY_A, 6'd9,  6'd0,  6'd0,  6'd0,  '0, '0));
        // Undefined operation codes leave the determinant alone.
        queue_job(make_job(OP_W'(11),    6'd1,  6'd2,  6'd3,  6'd4,
                           ALL_ONES, ALL_ONES));
        queue_job(make_job(OP_W'(15),    6'd63, 6'd63, 6'd63, 6'd63,
                           ALL_ONES, ALL_ONES));
        queue_job(make_job(OP_LOAD,      6'd0,  6'd0,  6'd0,  6'd0,  '0, '0));

        // The random run; the sender waits for the pipeline to empty at its
        // start and after each third of the random operations.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            job = random_job();
            job.drain = (n == 0) || (n == RANDOM_OPS / 3) || (n == (2 * RANDOM_OPS) / 3);
            queue_job(job);
        end
        total_ops = pending_ops.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample a little after each edge, once every update has settled.
        while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        mismatches += expected_results.size();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
